// File: hdl/i2crtd_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the I2C register transaction decoder.
// Used by i2crtd_core, i2crtd_queue and the top level; depends on nothing.
package i2crtd_pkg;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_RESTART = 3'd1;
  localparam logic [2:0] KIND_STOP    = 3'd2;
  localparam logic [2:0] KIND_ADDRESS = 3'd3;
  localparam logic [2:0] KIND_DATA    = 3'd4;
  localparam logic [2:0] KIND_ACK     = 3'd5;

  localparam logic [2:0] EV_SELECT     = 3'd0;
  localparam logic [2:0] EV_POINTER    = 3'd1;
  localparam logic [2:0] EV_MARK_READ  = 3'd2;
  localparam logic [2:0] EV_MARK_WRITE = 3'd3;
  localparam logic [2:0] EV_DATA       = 3'd4;
  localparam logic [2:0] EV_DONE       = 3'd5;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_PTR_LEN        = 2'd1;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h90;
  localparam logic [2:0]  PTR_LEN_RST        = 3'd1;
  localparam logic [7:0]  ADDR_MASK          = 8'hfe;
  localparam logic [15:0] BYTE_COUNT_MAX     = 16'hffff;

  typedef enum logic [3:0] {
    PH_WAIT_START = 4'd0,
    PH_ADDR       = 4'd1,
    PH_ADDR_ACK   = 4'd2,
    PH_PTR        = 4'd3,
    PH_PTR_ACK    = 4'd4,
    PH_DIR        = 4'd5,
    PH_RD_ADDR    = 4'd6,
    PH_RD_ACK     = 4'd7,
    PH_RD_DATA    = 4'd8,
    PH_DATA_ACK   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } event_t;

  // Up to two results caused by one symbol.
  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } push_t;

  typedef struct packed {
    logic full;
  } qstat_t;

endpackage

// File: hdl/i2c_register_transaction_decoder.sv
`timescale 1ns / 1ps
// I2C register transaction decoder, top level.
// A symbol is registered in a stage and stepped through the state machine
// while the result queue is not full; its results go to that queue.
// One symbol per cycle while the queue is not full; a symbol with two results
// is offered as two beats, and a full two-entry result queue stalls input.
// Reset (rst_n, synchronous): waits for start, registers take their defaults.
module i2c_register_transaction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_symbol_kind,
  input  logic [7:0]  in_symbol_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [31:0] out_event_value,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       cfg_we;
  logic [7:0] device_address_r;
  logic [2:0] ptr_len_r;

  logic       stage_v_r, stage_v_nxt;
  logic [2:0] stage_kind_r;
  logic [7:0] stage_byte_r;
  logic       in_beat;
  logic       advance;

  i2crtd_pkg::push_t  push;
  i2crtd_pkg::qstat_t qstat;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= i2crtd_pkg::DEVICE_ADDRESS_RST;
      ptr_len_r        <= i2crtd_pkg::PTR_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2crtd_pkg::CFG_DEVICE_ADDRESS: device_address_r <= cfg_data;
        i2crtd_pkg::CFG_PTR_LEN:        ptr_len_r        <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Hold the staged symbol while the result queue is full.
  assign advance     = stage_v_r && !qstat.full;
  assign in_stall    = stage_v_r && qstat.full;
  assign in_beat     = in_valid && !in_stall;
  assign stage_v_nxt = in_beat || (stage_v_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      stage_kind_r <= in_symbol_kind;
      stage_byte_r <= in_symbol_byte;
    end
  end

  i2crtd_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .symbol_kind    (stage_kind_r),
    .symbol_byte    (stage_byte_r),
    .device_address (device_address_r),
    .ptr_len        (ptr_len_r),
    .push           (push)
  );

  i2crtd_queue u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_event_value (out_event_value),
    .out_last_of_run (out_last_of_run),
    .stat            (qstat)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> (push.count == 2'd0))
    else $error("result pushed into a full queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind == i2crtd_pkg::EV_DONE ||
                   out_event_kind == i2crtd_pkg::EV_SELECT ||
                   out_event_kind == i2crtd_pkg::EV_POINTER)) |-> out_last_of_run)
    else $error("single result beat not marked last");

  a_mark_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == i2crtd_pkg::EV_MARK_WRITE) |-> !out_last_of_run)
    else $error("mark write beat marked last");

  a_stall_only_when_staged: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stage_v_r && $past(stage_v_r || in_valid)))
    else $error("input stalled with empty stage");

endmodule

// File: hdl/i2crtd_core.sv
`timescale 1ns / 1ps
// Transaction state machine: consumes one bus symbol per step and
// produces up to two result events. Depends on i2crtd_pkg.
module i2crtd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [2:0]           symbol_kind,
  input  logic [7:0]           symbol_byte,
  input  logic [7:0]           device_address,
  input  logic [2:0]           ptr_len,
  output i2crtd_pkg::push_t    push
);

  i2crtd_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] ptr_r, ptr_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;
  logic [7:0]  sel_r, sel_nxt;
  logic [15:0] bcnt_r, bcnt_nxt;

  logic        ack_ok;
  logic        wr_match;
  logic        rd_match;
  logic [15:0] bcnt_inc;
  logic [2:0]  pcnt_inc;

  assign ack_ok   = (symbol_kind == i2crtd_pkg::KIND_ACK) && (symbol_byte == 8'd0);
  assign wr_match = (symbol_kind == i2crtd_pkg::KIND_ADDRESS) &&
                    ((symbol_byte & i2crtd_pkg::ADDR_MASK) == device_address) &&
                    !symbol_byte[0];
  assign rd_match = (symbol_kind == i2crtd_pkg::KIND_ADDRESS) &&
                    (symbol_byte[7:1] == sel_r[7:1]) && symbol_byte[0];
  assign bcnt_inc = (bcnt_r != i2crtd_pkg::BYTE_COUNT_MAX) ? bcnt_r + 16'd1 : bcnt_r;
  assign pcnt_inc = (pcnt_r != 3'd7) ? pcnt_r + 3'd1 : pcnt_r;

  // Next state
  always_comb begin
    phase_nxt = i2crtd_pkg::PH_WAIT_START;
    ptr_nxt   = ptr_r;
    pcnt_nxt  = pcnt_r;
    sel_nxt   = sel_r;
    bcnt_nxt  = bcnt_r;
    unique case (phase_r)
      i2crtd_pkg::PH_WAIT_START: begin
        if (symbol_kind == i2crtd_pkg::KIND_START ||
            symbol_kind == i2crtd_pkg::KIND_RESTART) begin
          bcnt_nxt  = 16'd0;
          phase_nxt = i2crtd_pkg::PH_ADDR;
        end
      end
      i2crtd_pkg::PH_ADDR: begin
        if (wr_match) begin
          sel_nxt   = symbol_byte;
          phase_nxt = i2crtd_pkg::PH_ADDR_ACK;
        end
      end
      i2crtd_pkg::PH_ADDR_ACK: begin
        if (ack_ok) begin
          ptr_nxt   = 32'd0;
          pcnt_nxt  = 3'd0;
          phase_nxt = i2crtd_pkg::PH_PTR;
        end
      end
      i2crtd_pkg::PH_PTR: begin
        if (symbol_kind == i2crtd_pkg::KIND_DATA) begin
          ptr_nxt   = {ptr_r[23:0], symbol_byte};
          pcnt_nxt  = pcnt_inc;
          phase_nxt = i2crtd_pkg::PH_PTR_ACK;
        end
      end
      i2crtd_pkg::PH_PTR_ACK: begin
        if (ack_ok) begin
          phase_nxt = (pcnt_r >= ptr_len) ? i2crtd_pkg::PH_DIR : i2crtd_pkg::PH_PTR;
        end
      end
      i2crtd_pkg::PH_DIR: begin
        if (symbol_kind == i2crtd_pkg::KIND_STOP) begin
          phase_nxt = i2crtd_pkg::PH_DIR;
        end else if (symbol_kind == i2crtd_pkg::KIND_RESTART ||
                     symbol_kind == i2crtd_pkg::KIND_START) begin
          phase_nxt = i2crtd_pkg::PH_RD_ADDR;
        end else if (symbol_kind == i2crtd_pkg::KIND_DATA) begin
          bcnt_nxt  = bcnt_inc;
          phase_nxt = i2crtd_pkg::PH_DATA_ACK;
        end
      end
      i2crtd_pkg::PH_RD_ADDR: begin
        if (rd_match) begin
          phase_nxt = i2crtd_pkg::PH_RD_ACK;
        end
      end
      i2crtd_pkg::PH_RD_ACK: begin
        if (ack_ok) begin
          phase_nxt = i2crtd_pkg::PH_RD_DATA;
        end
      end
      i2crtd_pkg::PH_RD_DATA: begin
        if (symbol_kind == i2crtd_pkg::KIND_DATA) begin
          bcnt_nxt  = bcnt_inc;
          phase_nxt = i2crtd_pkg::PH_DATA_ACK;
        end
      end
      i2crtd_pkg::PH_DATA_ACK: begin
        if (ack_ok) begin
          phase_nxt = i2crtd_pkg::PH_RD_DATA;
        end
      end
      default: begin
        phase_nxt = i2crtd_pkg::PH_WAIT_START;
      end
    endcase
  end

  // Result events
  always_comb begin
    push.count = 2'd0;
    push.ev0   = '0;
    push.ev1   = '0;
    unique case (phase_r)
      i2crtd_pkg::PH_ADDR: begin
        if (wr_match) begin
          push.count = 2'd1;
          push.ev0   = '{kind: i2crtd_pkg::EV_SELECT, value: {24'd0, symbol_byte}};
        end
      end
      i2crtd_pkg::PH_PTR_ACK: begin
        if (ack_ok && (pcnt_r >= ptr_len)) begin
          push.count = 2'd1;
          push.ev0   = '{kind: i2crtd_pkg::EV_POINTER, value: ptr_r};
        end
      end
      i2crtd_pkg::PH_DIR: begin
        if (symbol_kind == i2crtd_pkg::KIND_RESTART ||
            symbol_kind == i2crtd_pkg::KIND_START) begin
          push.count = 2'd1;
          push.ev0   = '{kind: i2crtd_pkg::EV_MARK_READ, value: 32'd0};
        end else if (symbol_kind == i2crtd_pkg::KIND_DATA) begin
          push.count = 2'd2;
          push.ev0   = '{kind: i2crtd_pkg::EV_MARK_WRITE, value: 32'd0};
          push.ev1   = '{kind: i2crtd_pkg::EV_DATA, value: {24'd0, symbol_byte}};
        end
      end
      i2crtd_pkg::PH_RD_DATA: begin
        if (symbol_kind == i2crtd_pkg::KIND_DATA) begin
          push.count = 2'd1;
          push.ev0   = '{kind: i2crtd_pkg::EV_DATA, value: {24'd0, symbol_byte}};
        end else if (symbol_kind == i2crtd_pkg::KIND_STOP) begin
          push.count = 2'd1;
          push.ev0   = '{kind: i2crtd_pkg::EV_DONE, value: {16'd0, bcnt_r}};
        end
      end
      i2crtd_pkg::PH_DATA_ACK: begin
        // NAK after a data byte closes the transaction
        if (symbol_kind == i2crtd_pkg::KIND_ACK && symbol_byte != 8'd0) begin
          push.count = 2'd1;
          push.ev0   = '{kind: i2crtd_pkg::EV_DONE, value: {16'd0, bcnt_r}};
        end
      end
      default: begin
        push.count = 2'd0;
      end
    endcase
    if (!step) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2crtd_pkg::PH_WAIT_START;
      ptr_r   <= 32'd0;
      pcnt_r  <= 3'd0;
      sel_r   <= 8'd0;
      bcnt_r  <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ptr_r   <= ptr_nxt;
      pcnt_r  <= pcnt_nxt;
      sel_r   <= sel_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

endmodule

// File: hdl/i2crtd_queue.sv
`timescale 1ns / 1ps
// Two-entry result queue; each entry holds the one or two events of a
// symbol and is drained one beat at a time. Depends on i2crtd_pkg.
module i2crtd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  i2crtd_pkg::push_t   push,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_event_kind,
  output logic [31:0]         out_event_value,
  output logic                out_last_of_run,
  output i2crtd_pkg::qstat_t  stat
);

  i2crtd_pkg::push_t mem_r [2];
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              half_r, half_nxt;
  logic              wr_en;
  logic              pop;
  logic              entry_done;
  i2crtd_pkg::push_t head;
  i2crtd_pkg::event_t cur;

  assign head       = mem_r[rp_r];
  assign cur        = half_r ? head.ev1 : head.ev0;
  assign out_valid  = (cnt_r != 2'd0);
  assign out_event_kind  = cur.kind;
  assign out_event_value = cur.value;
  assign out_last_of_run = half_r || (head.count == 2'd1);

  assign wr_en      = (push.count != 2'd0);
  assign pop        = out_valid && !out_stall;
  assign entry_done = pop && out_last_of_run;

  assign stat.full  = (cnt_r == 2'd2);

  always_comb begin
    wp_nxt   = wr_en ? ~wp_r : wp_r;
    rp_nxt   = entry_done ? ~rp_r : rp_r;
    // advance to the second event, or back to the first once the entry drains
    half_nxt = pop ? !out_last_of_run : half_r;
    cnt_nxt  = cnt_r + {1'b0, wr_en} - {1'b0, entry_done};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
      half_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
      half_r <= half_nxt;
    end
  end

endmodule

// File: verif/i2c_register_transaction_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking bench for i2c_register_transaction_decoder: random register
// transactions under bursty input and stalled output, checked against an
// in-bench decoder model. Depends on i2crtd_pkg and the top level only.
module i2c_register_transaction_decoder_test;

  localparam logic [2:0] KIND_OTHER    = 3'd6;
  localparam logic [2:0] KIND_RESERVED = 3'd7;
  localparam int         SETTLE        = 20;
  localparam int         LIMIT         = 2000000;
  localparam int         HOLD_OFF      = 300;
  localparam int         PHASE_ITEMS   = 90;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data_byte;
  } bus_sym_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } bus_event_t;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_symbol_kind = '0;
  logic [7:0]  in_symbol_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_kind;
  logic [31:0] out_event_value;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  i2c_register_transaction_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol_kind  (in_symbol_kind),
    .in_symbol_byte  (in_symbol_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_event_value (out_event_value),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  bus_sym_t   sym_q[$];
  bus_event_t decoded_q[$];
  int         queued = 0;
  int         errors = 0;
  int         cycles = 0;
  logic       junk_on = 1'b0;
  logic       hold_req = 1'b0;

  // Decoder model state and its copy of the registers
  logic [7:0]          dev_addr = i2crtd_pkg::DEVICE_ADDRESS_RST;
  logic [2:0]          ptr_bytes = i2crtd_pkg::PTR_LEN_RST;
  i2crtd_pkg::phase_t  ph = i2crtd_pkg::PH_WAIT_START;
  logic [31:0]         reg_ptr = '0;
  logic [2:0]          ptr_cnt = '0;
  logic [7:0]          sel_dev = '0;
  logic [15:0]         byte_cnt = '0;

  function automatic bus_event_t mk_ev(input logic [2:0] k, input logic [31:0] v);
    bus_event_t e;
    e.kind = k;
    e.value = v;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic void decode_symbol(input logic [2:0] kind, input logic [7:0] b);
    bus_event_t evs[$];
    logic       nak;
    nak = (b != 8'd0);
    case (ph)
      i2crtd_pkg::PH_WAIT_START: begin
        if (kind == i2crtd_pkg::KIND_START || kind == i2crtd_pkg::KIND_RESTART) begin
          byte_cnt = '0;
          ph = i2crtd_pkg::PH_ADDR;
        end
      end
      i2crtd_pkg::PH_ADDR: begin
        if (kind == i2crtd_pkg::KIND_ADDRESS &&
            (b & i2crtd_pkg::ADDR_MASK) == dev_addr && !b[0]) begin
          sel_dev = b;
          evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_SELECT, {24'd0, b}));
          ph = i2crtd_pkg::PH_ADDR_ACK;
        end else begin
          ph = i2crtd_pkg::PH_WAIT_START;
        end
      end
      i2crtd_pkg::PH_ADDR_ACK: begin
        if (kind == i2crtd_pkg::KIND_ACK && !nak) begin
          reg_ptr = '0;
          ptr_cnt = '0;
          ph = i2crtd_pkg::PH_PTR;
        end else begin
          ph = i2crtd_pkg::PH_WAIT_START;
        end
      end
      i2crtd_pkg::PH_PTR: begin
        if (kind == i2crtd_pkg::KIND_DATA) begin
          reg_ptr = {reg_ptr[23:0], b};
          if (ptr_cnt != 3'd7) ptr_cnt = ptr_cnt + 3'd1;
          ph = i2crtd_pkg::PH_PTR_ACK;
        end else begin
          ph = i2crtd_pkg::PH_WAIT_START;
        end
      end
      i2crtd_pkg::PH_PTR_ACK: begin
        if (kind == i2crtd_pkg::KIND_ACK && !nak) begin
          if (ptr_cnt >= ptr_bytes) begin
            evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_POINTER, reg_ptr));
            ph = i2crtd_pkg::PH_DIR;
          end else begin
            ph = i2crtd_pkg::PH_PTR;
          end
        end else begin
          ph = i2crtd_pkg::PH_WAIT_START;
        end
      end
      i2crtd_pkg::PH_DIR: begin
        // a stop between pointer and direction is ignored
        if (kind == i2crtd_pkg::KIND_STOP) begin
        end else if (kind == i2crtd_pkg::KIND_RESTART || kind == i2crtd_pkg::KIND_START) begin
          evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_MARK_READ, 32'd0));
          ph = i2crtd_pkg::PH_RD_ADDR;
        end else if (kind == i2crtd_pkg::KIND_DATA) begin
          evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_MARK_WRITE, 32'd0));
          evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_DATA, {24'd0, b}));
          if (byte_cnt != i2crtd_pkg::BYTE_COUNT_MAX) byte_cnt = byte_cnt + 16'd1;
          ph = i2crtd_pkg::PH_DATA_ACK;
        end else begin
          ph = i2crtd_pkg::PH_WAIT_START;
        end
      end
      i2crtd_pkg::PH_RD_ADDR: begin
        if (kind == i2crtd_pkg::KIND_ADDRESS &&
            (b & i2crtd_pkg::ADDR_MASK) == (sel_dev & i2crtd_pkg::ADDR_MASK) && b[0])
          ph = i2crtd_pkg::PH_RD_ACK;
        else
          ph = i2crtd_pkg::PH_WAIT_START;
      end
      i2crtd_pkg::PH_RD_ACK: begin
        ph = (kind == i2crtd_pkg::KIND_ACK && !nak) ? i2crtd_pkg::PH_RD_DATA
                                                    : i2crtd_pkg::PH_WAIT_START;
      end
      i2crtd_pkg::PH_RD_DATA: begin
        if (kind == i2crtd_pkg::KIND_DATA) begin
          evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_DATA, {24'd0, b}));
          if (byte_cnt != i2crtd_pkg::BYTE_COUNT_MAX) byte_cnt = byte_cnt + 16'd1;
          ph = i2crtd_pkg::PH_DATA_ACK;
        end else begin
          if (kind == i2crtd_pkg::KIND_STOP)
            evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_DONE, {16'd0, byte_cnt}));
          ph = i2crtd_pkg::PH_WAIT_START;
        end
      end
      i2crtd_pkg::PH_DATA_ACK: begin
        if (kind == i2crtd_pkg::KIND_ACK && nak) begin
          evs.insert(evs.size(), mk_ev(i2crtd_pkg::EV_DONE, {16'd0, byte_cnt}));
          ph = i2crtd_pkg::PH_WAIT_START;
        end else if (kind == i2crtd_pkg::KIND_ACK) begin
          ph = i2crtd_pkg::PH_RD_DATA;
        end else begin
          ph = i2crtd_pkg::PH_WAIT_START;
        end
      end
      default: ph = i2crtd_pkg::PH_WAIT_START;
    endcase
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) decoded_q.insert(decoded_q.size(), evs[i]);
  endfunction

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_symbol_kind <= '0;
      in_symbol_byte <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_symbol(in_symbol_kind, in_symbol_byte);
        void'(sym_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sym_q.size() != 0) begin
        in_valid <= 1'b1;
        in_symbol_kind <= sym_q[0].kind;
        in_symbol_byte <= sym_q[0].data_byte;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off
  rx_mode_t rx_mode = RX_FLOW;
  int       mode_left = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_OFF;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(10, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FLOW:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:  out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10)
          $display("unexpected beat: kind %0d value 0x%08h last %0b",
                   out_event_kind, out_event_value, out_last_of_run);
      end else if (out_event_kind !== decoded_q[0].kind
                   || out_event_value !== decoded_q[0].value
                   || out_last_of_run !== decoded_q[0].last) begin
        errors <= errors + 1;
        if (errors < 10)
          $display("mismatch: expected kind %0d value 0x%08h last %0b, got %0d 0x%08h %0b",
                   decoded_q[0].kind, decoded_q[0].value, decoded_q[0].last,
                   out_event_kind, out_event_value, out_last_of_run);
      end
      if (decoded_q.size() != 0) void'(decoded_q.pop_front());
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("i2c_register_transaction_decoder_test: errors");
      $finish;
    end
  end

  function automatic void push_sym(input logic [2:0] kind, input logic [7:0] b);
    bus_sym_t s;
    if (junk_on && $urandom_range(0, 39) == 0) begin
      s.kind = 3'($urandom_range(0, 7));
      s.data_byte = 8'($urandom_range(0, 255));
      sym_q.insert(sym_q.size(), s);
      queued++;
    end
    s.kind = kind;
    s.data_byte = b;
    sym_q.insert(sym_q.size(), s);
    queued++;
  endfunction

  // Mostly ACK; now and then a NAK with any nonzero byte
  function automatic logic [7:0] ack_byte();
    return ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
  endfunction

  function automatic logic [2:0] open_kind();
    return ($urandom_range(0, 1) == 1) ? i2crtd_pkg::KIND_START : i2crtd_pkg::KIND_RESTART;
  endfunction

  function automatic void queue_transaction();
    int         npt;
    int         nd;
    logic [7:0] dev;
    logic       rd;
    dev = dev_addr & i2crtd_pkg::ADDR_MASK;
    npt = (ptr_bytes == 3'd0) ? 1 : int'(ptr_bytes);
    if ($urandom_range(0, 9) == 0) npt = $urandom_range(1, 7);
    rd = ($urandom_range(0, 1) == 1);
    nd = rd ? $urandom_range(0, 4) : $urandom_range(1, 4);
    push_sym(open_kind(), 8'($urandom_range(0, 255)));
    push_sym(i2crtd_pkg::KIND_ADDRESS,
             ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : dev);
    push_sym(i2crtd_pkg::KIND_ACK, ack_byte());
    for (int i = 0; i < npt; i++) begin
      push_sym(i2crtd_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
      push_sym(i2crtd_pkg::KIND_ACK, ack_byte());
    end
    if ($urandom_range(0, 2) == 0) push_sym(i2crtd_pkg::KIND_STOP, 8'($urandom_range(0, 255)));
    if (rd) begin
      push_sym(open_kind(), 8'($urandom_range(0, 255)));
      push_sym(i2crtd_pkg::KIND_ADDRESS,
               ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : (dev | 8'd1));
      push_sym(i2crtd_pkg::KIND_ACK, ack_byte());
    end
    for (int i = 0; i < nd; i++) begin
      push_sym(i2crtd_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
      if (i < nd - 1) push_sym(i2crtd_pkg::KIND_ACK, ack_byte());
    end
    if (nd == 0) begin
      push_sym(i2crtd_pkg::KIND_STOP, 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 1) == 1) begin
      push_sym(i2crtd_pkg::KIND_ACK, 8'($urandom_range(1, 255)));
    end else begin
      push_sym(i2crtd_pkg::KIND_ACK, 8'd0);
      push_sym(i2crtd_pkg::KIND_STOP, 8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == i2crtd_pkg::CFG_DEVICE_ADDRESS) dev_addr = val;
    else ptr_bytes = val[2:0];
  endtask

  // Wait until every beat is in and every result is out, then let the
  // pipeline settle so no symbol is still in flight
  task automatic drain();
    while (sym_q.size() != 0 || decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  logic [7:0] addr_set[7] = '{8'h00, 8'hfe, 8'h91, 8'hff, 8'h3a, 8'h50, 8'ha4};
  logic [7:0] ptr_set[7]  = '{8'd4, 8'd0, 8'd2, 8'd7, 8'd5, 8'd3, 8'd6};

  initial begin
    int base;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset config, a write, a read, and stray kinds while idle
    push_sym(KIND_OTHER, 8'h00);
    push_sym(KIND_RESERVED, 8'hff);
    push_sym(i2crtd_pkg::KIND_START, 8'h00);
    push_sym(i2crtd_pkg::KIND_ADDRESS, 8'h90);
    push_sym(i2crtd_pkg::KIND_ACK, 8'h00);
    push_sym(i2crtd_pkg::KIND_DATA, 8'ha5);
    push_sym(i2crtd_pkg::KIND_ACK, 8'h00);
    push_sym(i2crtd_pkg::KIND_STOP, 8'h00);
    push_sym(i2crtd_pkg::KIND_DATA, 8'h00);
    push_sym(i2crtd_pkg::KIND_ACK, 8'h00);
    push_sym(i2crtd_pkg::KIND_DATA, 8'hff);
    push_sym(i2crtd_pkg::KIND_ACK, 8'hff);
    push_sym(i2crtd_pkg::KIND_RESTART, 8'h00);
    push_sym(i2crtd_pkg::KIND_ADDRESS, 8'h90);
    push_sym(i2crtd_pkg::KIND_ACK, 8'h00);
    push_sym(i2crtd_pkg::KIND_DATA, 8'h00);
    push_sym(i2crtd_pkg::KIND_ACK, 8'h00);
    push_sym(i2crtd_pkg::KIND_START, 8'h00);
    push_sym(i2crtd_pkg::KIND_ADDRESS, 8'h91);
    push_sym(i2crtd_pkg::KIND_ACK, 8'h00);
    push_sym(i2crtd_pkg::KIND_DATA, 8'h3c);
    push_sym(i2crtd_pkg::KIND_ACK, 8'h00);
    push_sym(i2crtd_pkg::KIND_STOP, 8'h00);
    drain();

    junk_on = 1'b1;
    foreach (addr_set[p]) begin
      write_reg(i2crtd_pkg::CFG_DEVICE_ADDRESS, addr_set[p]);
      write_reg(i2crtd_pkg::CFG_PTR_LEN, ptr_set[p]);
      if (p == 0) hold_req <= 1'b1;
      base = queued;
      while (queued - base < PHASE_ITEMS) queue_transaction();
      drain();
    end

    if (errors == 0)
      $display("i2c_register_transaction_decoder_test: clean");
    else
      $display("i2c_register_transaction_decoder_test: errors");
    $finish;
  end

endmodule
